@@ hdl/rgts_pkg.sv @@
// Package with shared types and constants of the trilinear grid sampler.
`timescale 1ns / 1ps
`default_nettype none
package rgts_pkg;
   localparam int CsrAddrBits = 5;
   localparam logic [2:0] RegGridDims = 3'd0;
   localparam logic [2:0] RegScaleX   = 3'd1;
   localparam logic [2:0] RegScaleY   = 3'd2;
   localparam logic [2:0] RegScaleZ   = 3'd3;
   localparam logic [2:0] RegOffsetX  = 3'd4;
   localparam logic [2:0] RegOffsetY  = 3'd5;
   localparam logic [2:0] RegOffsetZ  = 3'd6;
   localparam logic [17:0] GridDimsReset = 18'd133152;
   localparam logic ReqWrite = 1'b0;
   localparam logic ReqQuery = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MAP   = 8'b0000_0010,
      ST_CHECK = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_LERPX = 8'b0001_0000,
      ST_LERPY = 8'b0010_0000,
      ST_LERPZ = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

@@ hdl/rgts_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rgts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ hdl/regular_grid_trilinear_sampler_core.sv @@
// Top level of the trilinear grid sampler: registers, sequencer and shared datapath.
//
// Usage: the req_ channel carries either a sample write (req_type 0) or a point
// query (req_type 1). A write is stored on acceptance and gives no transfer on the
// rsp_ channel. A query gives exactly one rsp_ transfer with interp_value (signed
// Q16.8) and in_range.
// A query runs through one shared multiplier: three axis mappings, a range check,
// eight sample reads from the single-port sample RAM, then seven lerps, one product
// each; an out-of-range point skips the reads and lerps. req_ready is low while a
// query is in flight and while its result waits; otherwise writes can follow each
// other in every cycle.
// The result sits in an output register; if the receiver stalls, the block holds
// the result and waits, but may not accept a new item until it is taken.
// Reset clears the control state and sets the CSRs to their defaults; the sample
// memory is not cleared, and every sample must be written before a query uses it.
// Write CSRs via the APB-style csr_ port only while the block is idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none
module regular_grid_trilinear_sampler_core #(
   parameter int GRID_DIM    = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [4:0]  req_cell_x,
   input  wire logic [4:0]  req_cell_y,
   input  wire logic [4:0]  req_cell_z,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [23:0] rsp_interp_value,
   output logic             rsp_in_range,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [rgts_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import rgts_pkg::*;

   localparam int IdxBits  = $clog2(GRID_DIM);
   localparam int AddrBits = 3 * IdxBits;
   localparam int Depth    = 1 << AddrBits;
   localparam int SbWrite  = SAMPLE_BITS < 16 ? SAMPLE_BITS : 16;

   // Configuration registers.
   logic [17:0]        grid_dims_ff;
   logic [31:0]        scale_ff  [3];
   logic signed [31:0] offset_ff [3];

   wire csr_wr = csr_psel && csr_penable && csr_pwrite;
   wire [2:0] csr_idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_dims_ff <= GridDimsReset;
         for (int i = 0; i < 3; i++) begin
            scale_ff[i]  <= 32'h0001_0000;
            offset_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            RegGridDims: grid_dims_ff <= csr_pwdata[17:0];
            RegScaleX:   scale_ff[0]  <= csr_pwdata;
            RegScaleY:   scale_ff[1]  <= csr_pwdata;
            RegScaleZ:   scale_ff[2]  <= csr_pwdata;
            RegOffsetX:  offset_ff[0] <= csr_pwdata;
            RegOffsetY:  offset_ff[1] <= csr_pwdata;
            RegOffsetZ:  offset_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         RegGridDims: csr_prdata = {14'd0, grid_dims_ff};
         RegScaleX:   csr_prdata = scale_ff[0];
         RegScaleY:   csr_prdata = scale_ff[1];
         RegScaleZ:   csr_prdata = scale_ff[2];
         RegOffsetX:  csr_prdata = offset_ff[0];
         RegOffsetY:  csr_prdata = offset_ff[1];
         RegOffsetZ:  csr_prdata = offset_ff[2];
         default:     csr_prdata = '0;
      endcase
   end

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;       // axis or lerp-pair counter
   logic [3:0]  step_ff, step_in;       // read address / read data counter
   logic signed [31:0] pos_ff [3];
   logic [IdxBits-1:0] idx_ff [3];
   logic [15:0] frac_ff [3];
   logic        oor_ff, oor_in;
   logic signed [47:0] g_ff [3];
   logic signed [SAMPLE_BITS-1:0] smp_ff [8];
   logic signed [SAMPLE_BITS+17:0] acc_ff [4]; // x-lerps, then y, then z
   logic        rsp_valid_ff;
   logic signed [23:0] rsp_value_ff;
   logic        rsp_range_ff;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_in_range = rsp_range_ff;
   wire req_fire = req_valid && req_ready;

   // Shared multiplier: one signed 33x33 product per cycle.
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // Lerp operands for the current step.
   logic signed [SAMPLE_BITS+17:0] lo_op, hi_op;
   logic signed [32:0] diff;
   always_comb begin
      lo_op = '0;
      hi_op = '0;
      mul_a = '0;
      mul_b = '0;
      diff  = '0;
      unique case (state_ff)
         ST_MAP: begin
            mul_a = {pos_ff[axis_ff][31], pos_ff[axis_ff]};
            mul_b = {1'b0, scale_ff[axis_ff]};
         end
         ST_LERPX: begin
            lo_op = (SAMPLE_BITS+18)'(smp_ff[{axis_ff, 1'b0}]);
            hi_op = (SAMPLE_BITS+18)'(smp_ff[{axis_ff, 1'b1}]);
            diff  = 33'(hi_op - lo_op);
            mul_a = diff;
            mul_b = {17'd0, frac_ff[0]};
         end
         ST_LERPY: begin
            lo_op = acc_ff[axis_ff];
            hi_op = acc_ff[axis_ff + 2'd2];
            diff  = 33'(hi_op - lo_op);
            mul_a = diff;
            mul_b = {17'd0, frac_ff[1]};
         end
         ST_LERPZ: begin
            lo_op = acc_ff[0];
            hi_op = acc_ff[1];
            diff  = 33'(hi_op - lo_op);
            mul_a = diff;
            mul_b = {17'd0, frac_ff[2]};
         end
         default: ;
      endcase
   end

   // Rounded lerp result a + floor((d*f + 0x8000) / 2^16); x stage is exact.
   logic signed [65:0] rnd;
   logic signed [SAMPLE_BITS+17:0] lerp_res;
   always_comb begin
      rnd = mul_p + 66'sd32768;
      if (state_ff == ST_LERPX) begin
         lerp_res = (SAMPLE_BITS+18)'((lo_op <<< 16) + mul_p);
      end else begin
         lerp_res = (SAMPLE_BITS+18)'(lo_op + (rnd >>> 16));
      end
   end

   // Per-axis range check.
   function automatic logic [8:0] dim_sat(input logic [5:0] n);
      return (9'(n) > 9'(GRID_DIM)) ? 9'(GRID_DIM) : 9'(n);
   endfunction

   logic        chk_bad;
   logic [47:0] chk_i;
   always_comb begin
      chk_bad = 1'b0;
      chk_i   = '0;
      for (int a = 0; a < 3; a++) begin
         chk_i = 48'(g_ff[a] >>> 16);
         if (g_ff[a] < 0 || dim_sat(grid_dims_ff[6*a +: 6]) < 9'd2 ||
             chk_i + 48'd1 >= 48'(dim_sat(grid_dims_ff[6*a +: 6]))) begin
            chk_bad = 1'b1;
         end
      end
   end

   // RAM address: write index or corner of the current read step.
   logic                wr_en;
   logic [AddrBits-1:0] ram_addr;
   logic [SAMPLE_BITS-1:0] wr_data, rd_data;
   logic [IdxBits-1:0]  ax, ay, az;
   logic signed [15:0]  wr_sext;
   always_comb begin
      wr_sext = 16'(signed'(req_sample_value[SbWrite-1:0]));
      wr_data = SAMPLE_BITS'(wr_sext);
      wr_en = req_fire && req_type == ReqWrite &&
              32'(req_cell_x) < GRID_DIM && 32'(req_cell_y) < GRID_DIM &&
              32'(req_cell_z) < GRID_DIM;
      // Step bits: 0 is x+1, 1 is z+1, 2 is y+1, so pairs are (lo, hi) in x.
      ax = idx_ff[0] + IdxBits'(step_ff[0]);
      az = idx_ff[2] + IdxBits'(step_ff[1]);
      ay = idx_ff[1] + IdxBits'(step_ff[2]);
      if (wr_en) begin
         ram_addr = {IdxBits'(req_cell_z), IdxBits'(req_cell_y), IdxBits'(req_cell_x)};
      end else begin
         ram_addr = {az, ay, ax};
      end
   end

   rgts_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(Depth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (ram_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      oor_in   = oor_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_type == ReqQuery) begin
               state_in = ST_MAP;
               axis_in  = '0;
            end
         end
         ST_MAP: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_CHECK;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            oor_in = chk_bad;
            step_in = '0;
            state_in = chk_bad ? ST_OUT : ST_READ;
         end
         ST_READ: begin
            // Address is issued at step, data lands in the cycle after.
            if (step_ff == 4'd8) begin
               state_in = ST_LERPX;
               axis_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_LERPX: begin
            if (axis_ff == 2'd3) begin
               state_in = ST_LERPY;
               axis_in  = '0;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_LERPY: begin
            if (axis_ff == 2'd1) begin
               state_in = ST_LERPZ;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_LERPZ: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Final Q.16 to Q.8 rounding with saturation.
   logic signed [SAMPLE_BITS+17:0] fin_r;
   logic signed [23:0] fin_v;
   always_comb begin
      fin_r = (acc_ff[0] + (SAMPLE_BITS+18)'(128)) >>> 8;
      if (fin_r > (SAMPLE_BITS+18)'(8388607)) begin
         fin_v = 24'sh7FFFFF;
      end else if (fin_r < -(SAMPLE_BITS+18)'(8388608)) begin
         fin_v = 24'sh800000;
      end else begin
         fin_v = 24'(fin_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         step_ff      <= '0;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
         oor_ff   <= oor_in;
         if (state_ff == ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (state_ff == ST_MAP) begin
         g_ff[axis_ff] <= 48'(mul_p >>> 16) - 48'(offset_ff[axis_ff]);
      end
      if (state_ff == ST_CHECK) begin
         for (int a = 0; a < 3; a++) begin
            idx_ff[a]  <= IdxBits'(g_ff[a] >>> 16);
            frac_ff[a] <= g_ff[a][15:0];
         end
      end
      if (state_ff == ST_READ && step_ff != 4'd0) begin
         smp_ff[3'(step_ff - 4'd1)] <= rd_data;
      end
      if (state_ff == ST_LERPX || state_ff == ST_LERPY) begin
         acc_ff[axis_ff] <= lerp_res;
      end
      // The z lerp leaves the final value where the output rounding reads it.
      if (state_ff == ST_LERPZ) begin
         acc_ff[0] <= lerp_res;
      end
      if (state_ff == ST_OUT) begin
         rsp_value_ff <= oor_ff ? 24'sd0 : fin_v;
         rsp_range_ff <= !oor_ff;
      end
   end

   // Checks on the sequencer.
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("req_ready outside idle");
   a_out_then_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid)
      else $error("result not presented");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_interp_value == 24'sd0)
      else $error("out-of-range result not zero");
endmodule
`default_nettype wire

@@ bench/regular_grid_trilinear_sampler_core_test.sv @@
// Testbench of the trilinear grid sampler: random and directed writes and queries checked by a scoreboard.
`timescale 1ns / 1ps
module regular_grid_trilinear_sampler_core_test;
   import rgts_pkg::*;

   class sampler_scoreboard;
      logic signed [15:0] samples [0:32767];
      bit written [0:32767];
      logic [17:0] dims;
      logic [31:0] scale [0:2];
      logic signed [31:0] offset [0:2];
      logic signed [23:0] want_value [$];
      logic want_range [$];
      int errors;

      function void reset_state();
         dims = GridDimsReset;
         for (int a = 0; a < 3; a++) begin
            scale[a] = 32'h10000;
            offset[a] = 0;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            RegGridDims: dims = v[17:0];
            RegScaleX: scale[0] = v;
            RegScaleY: scale[1] = v;
            RegScaleZ: scale[2] = v;
            RegOffsetX: offset[0] = v;
            RegOffsetY: offset[1] = v;
            RegOffsetZ: offset[2] = v;
            default: ;
         endcase
      endfunction

      // Floor of v / 2^sh; the arithmetic shift on a signed value already floors.
      function longint fl(longint v, int sh);
         return v >>> sh;
      endfunction

      function longint blend(longint a, longint b, longint f);
         return a + fl((b - a) * f + 32768, 16);
      endfunction

      function longint at(int x, int y, int z);
         return longint'(samples[(z * 32 + y) * 32 + x]);
      endfunction

      // Grid coordinate of one axis, or -1 when the point's cell leaves the grid.
      function longint grid_coord(int axis, logic signed [31:0] p);
         longint g;
         int n;
         n = (dims >> (6 * axis)) & 63;
         if (n > 32) n = 32;
         g = fl(longint'(p) * longint'({1'b0, scale[axis]}), 16) - longint'(offset[axis]);
         if (g < 0 || n < 2) return -1;
         if ((g >>> 16) + 1 >= n) return -1;
         return g;
      endfunction

      function bit cell_written(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz);
         longint gx, gy, gz;
         int ix, iy, iz;
         gx = grid_coord(0, px);
         gy = grid_coord(1, py);
         gz = grid_coord(2, pz);
         if (gx < 0 || gy < 0 || gz < 0) return 1;
         ix = gx >>> 16; iy = gy >>> 16; iz = gz >>> 16;
         for (int k = 0; k < 8; k++)
            if (!written[((iz + k[2]) * 32 + iy + k[1]) * 32 + ix + k[0]]) return 0;
         return 1;
      endfunction

      function void note_item(logic t, logic [4:0] cx, logic [4:0] cy, logic [4:0] cz,
                              logic signed [15:0] s, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz);
         longint gx, gy, gz, fx, fy, fz, x00, x01, x10, x11, y0, y1, v;
         int ix, iy, iz;
         if (t == ReqWrite) begin
            samples[(cz * 32 + cy) * 32 + cx] = s;
            written[(cz * 32 + cy) * 32 + cx] = 1;
            return;
         end
         gx = grid_coord(0, px);
         gy = grid_coord(1, py);
         gz = grid_coord(2, pz);
         if (gx < 0 || gy < 0 || gz < 0) begin
            want_value.push_back(0);
            want_range.push_back(0);
            return;
         end
         ix = gx >>> 16; iy = gy >>> 16; iz = gz >>> 16;
         fx = gx & 16'hFFFF; fy = gy & 16'hFFFF; fz = gz & 16'hFFFF;
         x00 = at(ix, iy, iz) * 65536 + (at(ix + 1, iy, iz) - at(ix, iy, iz)) * fx;
         x01 = at(ix, iy, iz + 1) * 65536
               + (at(ix + 1, iy, iz + 1) - at(ix, iy, iz + 1)) * fx;
         x10 = at(ix, iy + 1, iz) * 65536
               + (at(ix + 1, iy + 1, iz) - at(ix, iy + 1, iz)) * fx;
         x11 = at(ix, iy + 1, iz + 1) * 65536
               + (at(ix + 1, iy + 1, iz + 1) - at(ix, iy + 1, iz + 1)) * fx;
         y0 = blend(x00, x10, fy);
         y1 = blend(x01, x11, fy);
         v = fl(blend(y0, y1, fz) + 128, 8);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         want_value.push_back(v[23:0]);
         want_range.push_back(1);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic signed [23:0] v, logic r);
         if (want_value.size() == 0) begin
            report($sformatf("unexpected result value %0d in_range %0b", v, r));
            return;
         end
         if (v !== want_value[0])
            report($sformatf("interp_value %0d, expected %0d", v, want_value[0]));
         if (r !== want_range[0])
            report($sformatf("in_range %0b, expected %0b", r, want_range[0]));
         void'(want_value.pop_front());
         void'(want_range.pop_front());
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_type;
   logic [4:0] req_cell_x, req_cell_y, req_cell_z;
   logic signed [15:0] req_sample_value;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid, rsp_ready, rsp_in_range;
   logic signed [23:0] rsp_interp_value;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   sampler_scoreboard board;
   int send_idle, recv_stall;
   longint cycles;

   regular_grid_trilinear_sampler_core u_top (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Timeout");
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_interp_value, rsp_in_range);

   always @(negedge clock)
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall);

   always @(posedge clock)
      if (!reset && req_valid && req_ready)
         board.note_item(req_type, req_cell_x, req_cell_y, req_cell_z, req_sample_value,
                         req_pos_x, req_pos_y, req_pos_z);

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CsrAddrBits'(idx) << 2; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.set_reg(idx, v);
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic drain();
      req_valid <= 0;
      while (board.want_value.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Holds one item on the request channel until its transfer.
   task automatic send(logic t, logic [4:0] cx, logic [4:0] cy, logic [4:0] cz,
                       logic [15:0] s, logic [31:0] px, logic [31:0] py,
                       logic [31:0] pz);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_type <= t;
      req_cell_x <= cx; req_cell_y <= cy; req_cell_z <= cz;
      req_sample_value <= s;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put_sample(int x, int y, int z, logic [15:0] s);
      send(ReqWrite, x, y, z, s, $urandom, $urandom, $urandom);
   endtask

   task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      if (board.cell_written(px, py, pz))
         send(ReqQuery, $urandom, $urandom, $urandom, $urandom, px, py, pz);
   endtask

   // Mostly points inside the first n cells at unit scale, some anywhere.
   function automatic logic [31:0] near_point(int n);
      int r;
      r = $urandom_range(9);
      if (r == 0) return $urandom;
      if (r == 1) return -$urandom_range(200000);
      return $urandom_range(n * 65536 - 1);
   endfunction

   initial begin
      logic [15:0] sv;
      board = new();
      board.reset_state();
      cycles = 0;
      reset = 1;
      req_valid = 0; req_type = ReqWrite;
      req_cell_x = 0; req_cell_y = 0; req_cell_z = 0; req_sample_value = 0;
      req_pos_x = 0; req_pos_y = 0; req_pos_z = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle = 0; recv_stall = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Fill a small block at the origin and the far corner of the store.
      for (int k = 0; k < 64; k++) begin
         if (k % 9 == 0) sv = 16'h7FFF;
         else if (k % 7 == 0) sv = 16'h8000;
         else sv = $urandom;
         put_sample(k % 4, (k / 4) % 4, k / 16, sv);
      end
      for (int k = 0; k < 8; k++)
         put_sample(30 + k % 2, 30 + (k / 2) % 2, 30 + k / 4, $urandom);

      // Directed: extremes of samples and points, edges of the grid.
      put_sample(0, 0, 0, 16'h7FFF); put_sample(1, 0, 0, 16'h8000);
      put_sample(0, 1, 0, 16'h8000); put_sample(1, 1, 1, 16'h7FFF);
      query(0, 0, 0);
      query(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF);
      query(32'h00008000, 32'h00008000, 32'h00008000);
      query(32'h001E_FFFF, 32'h001E_FFFF, 32'h001E_FFFF);
      query(32'h001F_0000, 0, 0);
      query(0, 32'h001F_0000, 0);
      query(0, 0, 32'h001F_0000);
      query(32'hFFFF_FFFF, 0, 0);
      query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      query(32'h0001_8000, 32'hFFFF_0000, 32'h0002_4000);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         int nx, ny, nz;
         case (phase % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 81; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 81; end
            default: begin send_idle = 21; recv_stall = 21; end
         endcase
         nx = (phase == 1) ? 2 : (phase == 2) ? 63 : (phase == 5) ? 1 : $urandom_range(2, 33);
         ny = (phase == 1) ? 2 : (phase == 6) ? 0 : $urandom_range(2, 40);
         nz = (phase == 1) ? 2 : $urandom_range(2, 32);
         write_reg(RegGridDims, {$urandom} & ~32'h3FFFF | (nz << 12) | (ny << 6) | nx);
         // Scale and offset chosen at times so that grid space is the identity.
         if (phase < 2) begin
            write_reg(RegScaleX, 32'h10000); write_reg(RegScaleY, 32'h10000);
            write_reg(RegScaleZ, 32'h10000);
            write_reg(RegOffsetX, 0); write_reg(RegOffsetY, 0); write_reg(RegOffsetZ, 0);
         end else if (phase == 7) begin
            write_reg(RegScaleX, 32'hFFFF_FFFF); write_reg(RegScaleY, 0);
            write_reg(RegScaleZ, 32'h0000_0001);
            write_reg(RegOffsetX, 32'h8000_0000); write_reg(RegOffsetY, 32'h7FFF_FFFF);
            write_reg(RegOffsetZ, 32'hFFF0_0000);
         end else begin
            write_reg(RegScaleX, $urandom_range(32'h8000, 32'h30000));
            write_reg(RegScaleY, $urandom_range(32'h8000, 32'h30000));
            write_reg(RegScaleZ, $urandom_range(32'h8000, 32'h30000));
            write_reg(RegOffsetX, $urandom_range(0, 32'h40000) - 32'h20000);
            write_reg(RegOffsetY, $urandom_range(0, 32'h40000) - 32'h20000);
            write_reg(RegOffsetZ, $urandom_range(0, 32'h40000) - 32'h20000);
         end
         for (int i = 0; i < 90; i++) begin
            if ($urandom_range(4) == 0)
               put_sample($urandom, $urandom, $urandom, $urandom);
            else
               query(near_point(3), near_point(3), near_point(3));
            if (phase == 3 && i == 45) drain();
         end
         drain();
      end

      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ files.f @@
hdl/rgts_pkg.sv
hdl/rgts_ram.sv
hdl/regular_grid_trilinear_sampler_core.sv
bench/regular_grid_trilinear_sampler_core_test.sv
